// ----- hdl/slut_pkg.sv -----
// Package for the signed literal union table.
// Holds the beat structs, the table entry layout and the request and status codes.
// Depends on nothing; used by hdl/signed_literal_union_table.sv.
package slut_pkg;

	// Literal width: variable index in the upper bits, sign in bit 0.
	localparam int LIT_W = 11;
	// Number of variables an 11-bit literal can name.
	localparam int VAR_SPACE = 1 << (LIT_W - 1);
	// Variable counter width; it must hold VAR_SPACE itself.
	localparam int VC_W = LIT_W;

	localparam logic [1:0] FUNC_ALLOC = 2'd0;
	localparam logic [1:0] FUNC_FIND  = 2'd1;
	localparam logic [1:0] FUNC_TEST  = 2'd2;
	localparam logic [1:0] FUNC_MERGE = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]       func;
		logic [LIT_W-1:0] lit_a;
		logic [LIT_W-1:0] lit_b;
	} req_t;

	typedef struct packed {
		logic [LIT_W-1:0] lit_out;
		logic             can_merge;
		logic [1:0]       status;
	} rsp_t;

	// One table word: link flag, unmapped marker and the mapped literal.
	typedef struct packed {
		logic             link;
		logic             unmapped;
		logic [LIT_W-1:0] lit;
	} entry_t;

endpackage

// ----- hdl/signed_literal_union_table.sv -----
// Signed literal union table: union-find over signed literals with polarity.
// A request passes dispatch and done when it is an allocate or is settled by its operands alone;
// other tests and merges also pass read a and read b, and a find walks its links in the find state.
// The next request beat is taken once the sequencer is back in idle after done; a response beat
// that is still stalled holds the new response, and the input, back.
// Reset (arst_n, asynchronous, low) leaves variable 0 only, held as the true literal by logic.
module signed_literal_union_table #(
	parameter int MAX_VARS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  slut_pkg::req_t   req_data,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output slut_pkg::rsp_t   rsp_data
);

	// The table depth is the smaller of the parameter and what a literal can name.
	localparam int DEPTH = (MAX_VARS < slut_pkg::VAR_SPACE) ? MAX_VARS : slut_pkg::VAR_SPACE;
	localparam int AW = $clog2(DEPTH);
	localparam int LW = slut_pkg::LIT_W;
	localparam int VW = slut_pkg::VC_W;
	localparam logic [VW-1:0] VC_LIMIT = VW'(DEPTH);

	// Sequencer states.
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_RD_A     = 3'd2;
	localparam logic [2:0] S_RD_B     = 3'd3;
	localparam logic [2:0] S_FIND     = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0] state_q;

	// Request operands, held for the whole request.
	logic [1:0]    func_q;
	logic [LW-1:0] lit_a_q;
	logic [LW-1:0] lit_b_q;

	// Current literal and hop count of a find walk.
	logic [LW-1:0] cur_q;
	logic [VW-1:0] hops_q;

	// Number of allocated variables.
	logic [VW-1:0] var_count_q;

	// Result under construction, and the response register.
	logic [LW-1:0] res_lit_q;
	logic          res_can_q;
	logic [1:0]    res_status_q;
	logic          rsp_valid_q;
	slut_pkg::rsp_t rsp_q;

	// The table memory with one write and one registered read port.
	slut_pkg::entry_t mem [DEPTH];
	slut_pkg::entry_t rd_data_q;
	logic             rd_zero_q;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	slut_pkg::entry_t wr_data;

	// Entry of operand a, captured while operand b is being read.
	slut_pkg::entry_t ent_a_q;

	logic             accept;
	logic             rsp_load;
	logic             a_ok;
	logic             b_ok;
	logic             same_var;
	logic             full;
	slut_pkg::entry_t ent;
	logic [LW-1:0]    next_lit;
	logic [VW-1:0]    hops_nx;
	logic             too_long;
	logic             next_ok;
	logic             merge_ok;

	assign accept   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// Operand range checks compare the variable part against the allocation count.
	assign a_ok     = {1'b0, lit_a_q[LW-1:1]} < var_count_q;
	assign b_ok     = {1'b0, lit_b_q[LW-1:1]} < var_count_q;
	assign same_var = lit_a_q[LW-1:1] == lit_b_q[LW-1:1];
	assign full     = var_count_q >= VC_LIMIT;

	// Variable 0 is never written, so its constant entry (true literal, root) is
	// substituted on the read side.
	assign ent = rd_zero_q ? '0 : rd_data_q;

	// One hop of the find walk: follow the link and flip by the current sign.
	assign next_lit = ent.lit ^ {{(LW-1){1'b0}}, cur_q[0]};
	assign hops_nx  = hops_q + VW'(1);
	assign too_long = hops_nx > var_count_q;
	assign next_ok  = {1'b0, next_lit[LW-1:1]} < var_count_q;

	// Merge needs both operands to be roots; ent_a_q is a, ent is b here.
	assign merge_ok = !ent_a_q.link && !ent.link;

	// Memory port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = lit_a_q[AW:1];
		wr_en   = 1'b0;
		wr_addr = lit_a_q[AW:1];
		wr_data = '0;
		case (state_q)
			S_DISPATCH: begin
				case (func_q)
					slut_pkg::FUNC_ALLOC: begin
						if (!full) begin
							wr_en            = 1'b1;
							wr_addr          = var_count_q[AW-1:0];
							wr_data.unmapped = 1'b1;
						end
					end
					slut_pkg::FUNC_FIND: begin
						rd_en = a_ok;
					end
					default: begin
						rd_en = a_ok && b_ok && !same_var;
					end
				endcase
			end
			S_RD_A: begin
				rd_en   = 1'b1;
				rd_addr = lit_b_q[AW:1];
			end
			S_RD_B: begin
				if (func_q == slut_pkg::FUNC_MERGE && merge_ok) begin
					if (ent_a_q.unmapped) begin
						wr_en        = 1'b1;
						wr_data.link = 1'b1;
						wr_data.lit  = lit_b_q ^ {{(LW-1){1'b0}}, lit_a_q[0]};
					end else if (ent.unmapped) begin
						wr_en        = 1'b1;
						wr_addr      = lit_b_q[AW:1];
						wr_data.link = 1'b1;
						wr_data.lit  = lit_a_q ^ {{(LW-1){1'b0}}, lit_b_q[0]};
					end
				end
			end
			S_FIND: begin
				rd_addr = next_lit[AW:1];
				rd_en   = ent.link && !ent.unmapped && !too_long && next_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
			rd_zero_q <= (rd_addr == '0);
		end
	end

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			var_count_q <= VW'(1);
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (func_q)
						slut_pkg::FUNC_ALLOC: begin
							state_q <= S_DONE;
							if (!full) begin
								var_count_q <= var_count_q + VW'(1);
							end
						end
						slut_pkg::FUNC_FIND: begin
							state_q <= a_ok ? S_FIND : S_DONE;
						end
						default: begin
							state_q <= (a_ok && b_ok && !same_var) ? S_RD_A : S_DONE;
						end
					endcase
				end
				S_RD_A: begin
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					state_q <= S_DONE;
				end
				S_FIND: begin
					if (!rd_en) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q       <= req_data.func;
			lit_a_q      <= req_data.lit_a;
			lit_b_q      <= req_data.lit_b;
			cur_q        <= req_data.lit_a;
			hops_q       <= '0;
			res_lit_q    <= '0;
			res_can_q    <= 1'b0;
			res_status_q <= slut_pkg::ST_OK;
		end
		case (state_q)
			S_DISPATCH: begin
				case (func_q)
					slut_pkg::FUNC_ALLOC: begin
						if (full) begin
							res_status_q <= slut_pkg::ST_FULL;
						end else begin
							res_lit_q <= {var_count_q[LW-2:0], 1'b0};
						end
					end
					slut_pkg::FUNC_FIND: begin
						if (!a_ok) begin
							res_status_q <= slut_pkg::ST_BAD;
						end
					end
					slut_pkg::FUNC_TEST: begin
						if (!a_ok || !b_ok) begin
							res_status_q <= slut_pkg::ST_BAD;
						end
					end
					default: begin
						if (!a_ok || !b_ok || same_var) begin
							res_status_q <= slut_pkg::ST_BAD;
						end
					end
				endcase
			end
			S_RD_A: begin
				ent_a_q <= ent;
			end
			S_RD_B: begin
				if (func_q == slut_pkg::FUNC_TEST) begin
					res_can_q <= ent_a_q.unmapped || ent.unmapped;
				end else if (!merge_ok || (!ent_a_q.unmapped && !ent.unmapped)) begin
					res_status_q <= slut_pkg::ST_BAD;
				end
			end
			S_FIND: begin
				if (!ent.link) begin
					res_lit_q <= cur_q;
				end else if (!rd_en) begin
					res_status_q <= slut_pkg::ST_BAD;
				end
				cur_q  <= next_lit;
				hops_q <= hops_nx;
			end
			default: begin
			end
		endcase
		if (rsp_load) begin
			rsp_q.lit_out   <= res_lit_q;
			rsp_q.can_merge <= res_can_q;
			rsp_q.status    <= res_status_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

`ifndef SYNTHESIS
	// The allocation count stays within the table and never drops below variable 0.
	a_var_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(var_count_q != '0) && (var_count_q <= VC_LIMIT))
		else $error("variable count out of range");

	// The count moves only on an allocate that found room.
	a_var_count_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(var_count_q) |-> ($past(state_q) == S_DISPATCH &&
		$past(func_q) == slut_pkg::FUNC_ALLOC))
		else $error("variable count changed outside allocate");

	// A positive merge test always comes with an ok status.
	a_can_merge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.can_merge) |-> (rsp_data.status == slut_pkg::ST_OK))
		else $error("can_merge set with error status");

	// An accepted request beat always enters dispatch next.
	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_DISPATCH))
		else $error("accepted request did not dispatch");
`endif

endmodule

// ----- verif/union_table_checker.sv -----
// Scoreboard for the signed literal union table: keeps its own copy of the variable table,
// predicts the reply to every accepted request beat and compares each reply beat in order.
// Depends on slut_pkg for the beat structs and the request and status codes.
module union_table_checker #(
	parameter int MAX_VARS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  slut_pkg::req_t req_data,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  slut_pkg::rsp_t rsp_data,
	output int             fail_count,
	output int             pending,
	output int             checked,
	output int             full_replies,
	output int             deepest_chain
);

	localparam int LIT_W = slut_pkg::LIT_W;
	localparam int VAR_CAP = (MAX_VARS < slut_pkg::VAR_SPACE) ? MAX_VARS : slut_pkg::VAR_SPACE;

	logic [LIT_W-1:0] map_lit [slut_pkg::VAR_SPACE];
	bit               map_null [slut_pkg::VAR_SPACE];
	bit               linked [slut_pkg::VAR_SPACE];
	int unsigned      n_vars;
	slut_pkg::rsp_t   replies_due [$];
	int               errs;
	int               n_seen;
	int               n_full;
	int               longest_walk;

	function automatic bit lit_known(logic [LIT_W-1:0] lit);
		return lit[LIT_W-1:1] < n_vars;
	endfunction

	// Works out the reply to one request and applies its effect to the table copy.
	function automatic slut_pkg::rsp_t answer_request(slut_pkg::req_t r);
		slut_pkg::rsp_t   ans;
		logic [LIT_W-1:0] walk;
		logic [LIT_W-2:0] va;
		logic [LIT_W-2:0] vb;
		logic [LIT_W-2:0] v;
		logic [LIT_W-2:0] fresh;
		int unsigned      hops;
		ans = '0;
		va = r.lit_a[LIT_W-1:1];
		vb = r.lit_b[LIT_W-1:1];
		case (r.func)
		slut_pkg::FUNC_ALLOC: begin
			if (n_vars >= VAR_CAP) begin
				ans.status = slut_pkg::ST_FULL;
			end else begin
				fresh = n_vars[LIT_W-2:0];
				map_null[fresh] = 1'b1;
				linked[fresh] = 1'b0;
				ans.lit_out = LIT_W'(n_vars << 1);
				n_vars++;
			end
		end
		slut_pkg::FUNC_FIND: begin
			ans.status = slut_pkg::ST_BAD;
			if (lit_known(r.lit_a)) begin
				walk = r.lit_a;
				hops = 0;
				// Each hop flips the polarity by the sign of the literal that led there.
				while (hops <= n_vars) begin
					v = walk[LIT_W-1:1];
					if (v >= n_vars) break;
					if (!linked[v]) begin
						ans.status = slut_pkg::ST_OK;
						ans.lit_out = walk;
						break;
					end
					if (map_null[v]) break;
					walk = map_lit[v] ^ LIT_W'(walk[0]);
					hops++;
				end
				if (ans.status == slut_pkg::ST_OK && hops > longest_walk) longest_walk = hops;
			end
		end
		slut_pkg::FUNC_TEST: begin
			if (!lit_known(r.lit_a) || !lit_known(r.lit_b))
				ans.status = slut_pkg::ST_BAD;
			else
				ans.can_merge = (va != vb) && (map_null[va] || map_null[vb]);
		end
		slut_pkg::FUNC_MERGE: begin
			if (!lit_known(r.lit_a) || !lit_known(r.lit_b) || va == vb || linked[va] ||
					linked[vb]) begin
				ans.status = slut_pkg::ST_BAD;
			end else if (map_null[va]) begin
				map_lit[va] = r.lit_b ^ LIT_W'(r.lit_a[0]);
				map_null[va] = 1'b0;
				linked[va] = 1'b1;
			end else if (map_null[vb]) begin
				map_lit[vb] = r.lit_a ^ LIT_W'(r.lit_b[0]);
				map_null[vb] = 1'b0;
				linked[vb] = 1'b1;
			end else begin
				ans.status = slut_pkg::ST_BAD;
			end
		end
		default: begin
		end
		endcase
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		slut_pkg::rsp_t want;
		if (!arst_n) begin
			map_lit = '{default: '0};
			map_null = '{default: 1'b0};
			linked = '{default: 1'b0};
			n_vars = 1;
			replies_due.delete();
			errs = 0;
			n_seen = 0;
			n_full = 0;
			longest_walk = 0;
		end else begin
			// A reply leaving at this edge always belongs to an earlier request.
			if (rsp_valid && !rsp_stall) begin
				if (replies_due.size() == 0) begin
					errs++;
					$error("reply beat with no request outstanding: lit_out %0d status %0d",
						rsp_data.lit_out, rsp_data.status);
				end else begin
					want = replies_due.pop_front();
					n_seen++;
					if (want.status == slut_pkg::ST_FULL) n_full++;
					if (rsp_data.lit_out !== want.lit_out) begin
						errs++;
						$error("lit_out: expected %0d, got %0d", want.lit_out, rsp_data.lit_out);
					end
					if (rsp_data.can_merge !== want.can_merge) begin
						errs++;
						$error("can_merge: expected %0d, got %0d", want.can_merge,
							rsp_data.can_merge);
					end
					if (rsp_data.status !== want.status) begin
						errs++;
						$error("status: expected %0d, got %0d", want.status, rsp_data.status);
					end
				end
			end
			if (req_valid && !req_stall) replies_due.push_back(answer_request(req_data));
		end
		fail_count <= errs;
		pending <= replies_due.size();
		checked <= n_seen;
		full_replies <= n_full;
		deepest_chain <= longest_walk;
	end

endmodule

// ----- verif/tb_signed_literal_union_table.sv -----
// Testbench top for the signed literal union table: drives request beats, throttles
// reply beats, watches for a stuck run and prints the verdict.
// Depends on slut_pkg, union_table_checker and signed_literal_union_table.
module tb_signed_literal_union_table;

	localparam int LIT_W       = slut_pkg::LIT_W;
	localparam int TABLE_VARS  = 1024;
	// Request count after which stimulus stops, once the table has also been filled.
	localparam int ITEM_GOAL   = 1550;
	// From this request on, allocation dominates so that the table fills in time.
	localparam int FILL_START  = 500;
	// Covers a find over the longest possible chain, several times over, plus the long
	// receiver hold-off.
	localparam int QUIET_LIMIT = 20000;
	localparam int HOLD_OFF    = 250;
	localparam int HOLD_AT     = 400;

	logic           clk;
	logic           arst_n;
	logic           req_valid;
	logic           req_stall;
	slut_pkg::req_t req_data;
	logic           rsp_valid;
	logic           rsp_stall;
	slut_pkg::rsp_t rsp_data;

	int fail_count;
	int pending;
	int checked;
	int full_replies;
	int deepest_chain;
	int quiet_cycles = 0;

	// Stimulus bookkeeping only: how many variables the block will hold once every
	// allocate sent so far has landed, and the variables at both ends of the long chain.
	int unsigned vars_made;
	int          chain_root;
	int          chain_first;
	int          items_sent;
	bit          tx_calm;

	signed_literal_union_table #(
		.MAX_VARS(TABLE_VARS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	union_table_checker #(
		.MAX_VARS(TABLE_VARS)
	) scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req_data     (req_data),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp_data     (rsp_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.full_replies (full_replies),
		.deepest_chain(deepest_chain)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// The watchdog restarts its count on every beat on either channel. A run that
	// stops moving for too long is a failure.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_signed_literal_union_table: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [LIT_W-1:0] lit_of(int unsigned v, bit neg);
		return LIT_W'((v << 1) | neg);
	endfunction

	// Mostly a literal of a variable that exists, now and then any 11-bit value, which
	// is usually out of range.
	function automatic logic [LIT_W-1:0] pick_lit();
		if ($urandom_range(0, 9) == 0) return LIT_W'($urandom);
		return lit_of($urandom_range(0, vars_made - 1), 1'($urandom_range(0, 1)));
	endfunction

	// Random merges stay away from the head of the long chain, or they could link it
	// into another class and cut the chain short.
	function automatic logic [LIT_W-1:0] steer_off_chain(logic [LIT_W-1:0] lit);
		if (chain_root >= 0 && lit[LIT_W-1:1] == chain_root) return LIT_W'(lit[0]);
		return lit;
	endfunction

	// Offers one request beat after a random gap and returns at the edge that takes
	// it. Valid stays high afterwards, so back-to-back beats need no second assignment.
	task automatic send_req(input logic [1:0] f, input logic [LIT_W-1:0] a,
			input logic [LIT_W-1:0] b);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= '{func: f, lit_a: a, lit_b: b};
		do @(posedge clk); while (req_stall);
		if (f == slut_pkg::FUNC_ALLOC && vars_made < TABLE_VARS) vars_made++;
		items_sent++;
		// Every hundred beats, decide whether the next stretch is sent without gaps.
		if (items_sent % 100 == 0) tx_calm = ($urandom_range(0, 3) == 0);
	endtask

	// Adds one link to the long chain: a fresh variable is allocated and the current
	// head, still an unmapped root, is merged onto it. The fresh variable becomes the
	// new head, so a find from the first variable walks every link made so far.
	task automatic grow_chain();
		int fresh;
		fresh = int'(vars_made);
		send_req(slut_pkg::FUNC_ALLOC, LIT_W'($urandom), LIT_W'($urandom));
		if (chain_root < 0)
			chain_first = fresh;
		else
			send_req(slut_pkg::FUNC_MERGE, lit_of(chain_root, 1'($urandom_range(0, 1))),
				lit_of(fresh, 1'($urandom_range(0, 1))));
		chain_root = fresh;
	endtask

	task automatic probe_chain();
		send_req(slut_pkg::FUNC_FIND, lit_of(chain_first, 1'($urandom_range(0, 1))),
			LIT_W'($urandom));
	endtask

	// One step of the general mix: chain building, plain allocation, finds, tests,
	// random merges and a slice of pure noise with any operation and any operands.
	task automatic mixed_step();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 30) begin
			if (vars_made < TABLE_VARS)
				grow_chain();
			else
				probe_chain();
		end else if (roll < 45) begin
			send_req(slut_pkg::FUNC_ALLOC, LIT_W'($urandom), LIT_W'($urandom));
		end else if (roll < 62) begin
			if (chain_root >= 0 && roll < 53)
				probe_chain();
			else
				send_req(slut_pkg::FUNC_FIND, pick_lit(), LIT_W'($urandom));
		end else if (roll < 74) begin
			send_req(slut_pkg::FUNC_TEST, pick_lit(), pick_lit());
		end else if (roll < 92) begin
			send_req(slut_pkg::FUNC_MERGE, steer_off_chain(pick_lit()),
				steer_off_chain(pick_lit()));
		end else begin
			send_req(2'($urandom_range(0, 3)), LIT_W'($urandom), LIT_W'($urandom));
		end
	endtask

	initial begin : stimulus
		int unsigned roll;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req_data <= '0;
		vars_made = 1;
		chain_root = -1;
		chain_first = 0;
		items_sent = 0;
		tx_calm = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Variable 0 is the true literal right after reset, in both polarities, and a
		// test of a variable against itself says no.
		send_req(slut_pkg::FUNC_FIND, 11'd0, 11'd0);
		send_req(slut_pkg::FUNC_FIND, 11'd1, 11'd2047);
		send_req(slut_pkg::FUNC_TEST, 11'd0, 11'd1);
		// Three allocations give variables 1, 2 and 3; their operands are ignored.
		send_req(slut_pkg::FUNC_ALLOC, 11'd2047, 11'd2047);
		send_req(slut_pkg::FUNC_ALLOC, 11'd0, 11'd0);
		send_req(slut_pkg::FUNC_ALLOC, 11'd1365, 11'd682);
		// Operands beyond the allocated variables are rejected by every operation.
		send_req(slut_pkg::FUNC_FIND, 11'd2047, 11'd0);
		send_req(slut_pkg::FUNC_TEST, 11'd2047, 11'd0);
		send_req(slut_pkg::FUNC_TEST, 11'd0, 11'd2047);
		send_req(slut_pkg::FUNC_MERGE, 11'd2047, 11'd2);
		send_req(slut_pkg::FUNC_MERGE, 11'd0, 11'd2047);
		// Unmapped variables can be merged with the true literal and with each other.
		send_req(slut_pkg::FUNC_TEST, 11'd0, 11'd2);
		send_req(slut_pkg::FUNC_TEST, 11'd3, 11'd5);
		// The first operand unmapped: variable 1 gets linked to the false literal.
		send_req(slut_pkg::FUNC_MERGE, 11'd3, 11'd0);
		send_req(slut_pkg::FUNC_FIND, 11'd2, 11'd0);
		send_req(slut_pkg::FUNC_FIND, 11'd3, 11'd0);
		// The first operand mapped, so the second one (variable 2) gets linked.
		send_req(slut_pkg::FUNC_MERGE, 11'd0, 11'd5);
		// A linked operand, and the same variable twice, are both refused.
		send_req(slut_pkg::FUNC_MERGE, 11'd4, 11'd6);
		send_req(slut_pkg::FUNC_MERGE, 11'd6, 11'd7);
		// Two mapped variables can no longer be merged.
		send_req(slut_pkg::FUNC_TEST, 11'd2, 11'd4);
		// Variable 3 links to the positive literal of variable 0, the two negative signs cancelling, then its
		// root is found from both polarities.
		send_req(slut_pkg::FUNC_MERGE, 11'd7, 11'd1);
		send_req(slut_pkg::FUNC_FIND, 11'd6, 11'd0);
		send_req(slut_pkg::FUNC_FIND, 11'd7, 11'd0);

		// Random part. The table has to be filled to reach the table-full reply, so
		// after the general mix a phase heavy with allocation follows; once the table
		// is full, the mix continues with allocation answering full.
		while (items_sent < ITEM_GOAL || vars_made < TABLE_VARS) begin
			if (items_sent >= FILL_START && vars_made < TABLE_VARS) begin
				roll = $urandom_range(0, 99);
				if (roll < 75)
					send_req(slut_pkg::FUNC_ALLOC, LIT_W'($urandom), LIT_W'($urandom));
				else if (roll < 90)
					grow_chain();
				else
					probe_chain();
			end else begin
				mixed_step();
			end
		end
		req_valid <= 1'b0;

		// The checker's pending count is registered and lags behind the last request beat.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run sent %0d requests and checked %0d replies; %0d variables in use.",
			items_sent, checked, vars_made);
		$display("Table-full replies: %0d; longest chain walked by a find: %0d links.",
			full_replies, deepest_chain);
		if (fail_count == 0) begin
			$display("tb_signed_literal_union_table: PASS");
		end else begin
			$display("tb_signed_literal_union_table: FAIL");
		end
		$finish;
	end

	// The reply side draws a stall length for every beat. Every 64 beats it decides
	// whether the next stretch runs without stalls. Once, it holds off for a long
	// stretch while requests keep coming, so the block backs up and stalls its input.
	initial begin : reply_drain
		int gap;
		int taken;
		bit rx_calm;
		taken = 0;
		rx_calm = 1'b0;
		rsp_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (taken == HOLD_AT)
				gap = HOLD_OFF;
			else
				gap = rx_calm ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			taken++;
			if (taken % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
		end
	end

endmodule

// ----- filelist.f -----
hdl/slut_pkg.sv
hdl/signed_literal_union_table.sv
verif/union_table_checker.sv
verif/tb_signed_literal_union_table.sv
